// File: hw/rtl/contiguous_page_allocator_unit_defines.svh
// Assertion macros for the page allocator RTL.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while the reset is asserted.
`define CPA_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("contiguous_page_allocator_unit: check failed");
// Clocked check that also holds during reset.
`define CPA_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("contiguous_page_allocator_unit: check failed");
`else
`define CPA_ASSERT_RST(lbl, clk, rst_n, prop)
`define CPA_ASSERT(lbl, clk, prop)
`endif

`endif

// File: hw/rtl/cpa_pkg.sv
`timescale 1ns / 1ps

package cpa_pkg;

    // One table entry: a used bit above a 4-bit owner.
    localparam int ENTRY_W = 5;
    localparam int PID_W   = 4;

    typedef enum logic [1:0] {
        MODE_REQ  = 2'd0,
        MODE_REL  = 2'd1,
        MODE_QRY  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_BAD   = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOMEM  = 2'd1,
        ST_BADPOL = 2'd2
    } t_status;

    // Control handed from the sequencer to the run finder for each read beat.
    typedef struct packed {
        logic clr;
        logic beat;
        logic last;
        logic used;
    } t_scan_ctl;

    typedef struct packed {
        t_status           status;
        logic [7:0]        start_page;
        logic [8:0]        pages_granted;
        logic              page_free;
        logic [PID_W-1:0]  page_owner;
    } t_result;

endpackage

// File: hw/rtl/cpa_owner_ram.sv
`timescale 1ns / 1ps

module cpa_owner_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [cpa_pkg::ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [cpa_pkg::ENTRY_W-1:0] o_rdata
);
    import cpa_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/cpa_run_fit.sv
`timescale 1ns / 1ps

module cpa_run_fit #(
    parameter int PAGE_COUNT = 256,
    parameter int IDX_W      = 8,
    parameter int CNT_W      = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpa_pkg::t_scan_ctl i_ctl,
    input  logic [IDX_W-1:0]   i_addr,
    input  logic [CNT_W-1:0]   i_need,
    input  cpa_pkg::t_policy   i_policy,
    output logic               o_found,
    output logic [IDX_W-1:0]   o_start
);
    import cpa_pkg::*;

    logic             r_in_run;
    logic [IDX_W-1:0] r_cur_start;
    logic [CNT_W-1:0] r_cur_len;
    logic             r_found;
    logic [IDX_W-1:0] r_best_start;
    logic [CNT_W-1:0] r_best_len;

    logic [IDX_W-1:0] ext_start;
    logic [CNT_W-1:0] ext_len;
    logic             cand_vld;
    logic [IDX_W-1:0] cand_start;
    logic [CNT_W-1:0] cand_len;
    logic             take;

    // A run closes on a used page after free ones, or on a free last page.
    always_comb begin
        ext_start  = r_in_run ? r_cur_start : i_addr;
        ext_len    = r_in_run ? (r_cur_len + CNT_W'(1)) : CNT_W'(1);
        cand_vld   = (i_ctl.used && r_in_run) || (!i_ctl.used && i_ctl.last);
        cand_start = i_ctl.used ? r_cur_start : ext_start;
        cand_len   = i_ctl.used ? r_cur_len : ext_len;
        take = i_ctl.beat && cand_vld && (cand_len >= i_need) &&
               (!r_found ||
                ((i_policy == POL_BEST) && (cand_len < r_best_len)) ||
                ((i_policy == POL_WORST) && (cand_len > r_best_len)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_in_run <= 1'b0;
            r_found  <= 1'b0;
        end else if (i_ctl.beat) begin
            r_in_run <= !i_ctl.used;
            if (take) begin
                r_found <= 1'b1;
            end
        end
        if (i_ctl.beat && !i_ctl.used) begin
            r_cur_start <= ext_start;
            r_cur_len   <= ext_len;
        end
        if (take) begin
            r_best_start <= cand_start;
            r_best_len   <= cand_len;
        end
    end

    assign o_found = r_found;
    assign o_start = r_best_start;

endmodule

// File: hw/rtl/contiguous_page_allocator_unit.sv
`timescale 1ns / 1ps
`include "contiguous_page_allocator_unit_defines.svh"
//
// Channel   Direction  Handshake                   Payload
// s stream  in         i_s_tvalid / o_s_tready     i_s_tdata (40 bits, one command)
// m stream  out        o_m_tvalid / i_m_tready     o_m_tdata (24 bits, one result)
//
// After reset the owner table is cleared one entry per cycle, and no command
// is taken until that pass ends.
// A request or a release scans the full table through the single read
// port of the owner memory; a query reads only the one page it names.
// One command is worked on at a time; a finished result waits in the output
// register while the next command is already taken.
//
module contiguous_page_allocator_unit #(
    parameter int PAGE_COUNT = 256,  // pages in the table, 8 to 256
    parameter int PAGE_SIZE  = 4096  // bytes per page, a power of two
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // mode[1:0], process_id[5:2], size_bytes[26:6], fit_policy[28:27],
    // page_index[36:29], zeros above
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[1:0], start_page[9:2], pages_granted[18:10], page_free[19],
    // page_owner[23:20]
    output logic [23:0] o_m_tdata
);
    import cpa_pkg::*;

    localparam int IDX_W = $clog2(PAGE_COUNT);
    localparam int CNT_W = $clog2(PAGE_COUNT + 1);
    localparam int PG_SH = $clog2(PAGE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGE_COUNT - 1);
    localparam logic [20:0]      SZ_MASK  = 21'(PAGE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FILL,
        S_QRY,
        S_DONE
    } t_state;

    // Fields of the incoming transaction.
    t_mode       in_mode;
    logic [3:0]  in_pid;
    logic [20:0] in_size;
    t_policy     in_policy;
    logic [7:0]  in_pidx;
    logic [21:0] in_need;
    logic        in_need_big;
    logic [IDX_W-1:0] in_pidx_addr;

    assign in_mode   = t_mode'(i_s_tdata[1:0]);
    assign in_pid    = i_s_tdata[5:2];
    assign in_size   = i_s_tdata[26:6];
    assign in_policy = t_policy'(i_s_tdata[28:27]);
    assign in_pidx   = i_s_tdata[36:29];

    // Round the byte size up to whole pages.
    assign in_need      = 22'(in_size >> PG_SH) + 22'(|(in_size & SZ_MASK));
    assign in_need_big  = in_need > 22'(PAGE_COUNT);
    assign in_pidx_addr = IDX_W'({{IDX_W{1'b0}}, in_pidx});

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             r_issue, n_issue;
    logic             r_beat, n_beat;
    logic [IDX_W-1:0] r_beat_addr, n_beat_addr;
    logic [CNT_W-1:0] r_rem, n_rem;
    t_mode            r_mode, n_mode;
    logic [3:0]       r_pid, n_pid;
    t_policy          r_policy, n_policy;
    logic [CNT_W-1:0] r_need, n_need;
    logic             r_q_ok, n_q_ok;
    t_result          r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic [23:0]      r_out_data, n_out_data;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    t_scan_ctl        scan_ctl;
    logic             fit_found;
    logic [IDX_W-1:0] fit_start;
    logic             accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // A query reads its page straight from the incoming transaction.
    assign ram_raddr = (r_state == S_IDLE) ? in_pidx_addr : r_addr;

    assign scan_ctl.clr  = accept;
    assign scan_ctl.beat = r_beat && (r_mode == MODE_REQ);
    assign scan_ctl.last = (r_beat_addr == LAST_IDX);
    assign scan_ctl.used = ram_rdata[ENTRY_W-1];

    cpa_owner_ram #(
        .DEPTH (PAGE_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cpa_run_fit #(
        .PAGE_COUNT (PAGE_COUNT),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_fit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_addr   (r_beat_addr),
        .i_need   (r_need),
        .i_policy (r_policy),
        .o_found  (fit_found),
        .o_start  (fit_start)
    );

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_issue     = r_issue;
        n_beat      = 1'b0;
        n_beat_addr = r_addr;
        n_rem       = r_rem;
        n_mode      = r_mode;
        n_pid       = r_pid;
        n_policy    = r_policy;
        n_need      = r_need;
        n_q_ok      = r_q_ok;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;

        unique case (r_state)
            S_CLEAR: begin
                // Clearing pass: every entry becomes free with owner zero.
                ram_we = 1'b1;
                n_addr = r_addr + IDX_W'(1);
                if (r_addr == LAST_IDX) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_mode   = in_mode;
                    n_pid    = in_pid;
                    n_policy = in_policy;
                    n_need   = CNT_W'(in_need);
                    n_q_ok   = (32'(in_pidx) < 32'(PAGE_COUNT));
                    n_res    = '0;
                    n_addr   = '0;
                    unique case (in_mode)
                        MODE_REQ: begin
                            if (in_policy == POL_BAD) begin
                                n_res.status = ST_BADPOL;
                                n_state      = S_DONE;
                            end else if (in_need_big) begin
                                n_res.status = ST_NOMEM;
                                n_state      = S_DONE;
                            end else begin
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        MODE_REL: begin
                            n_issue = 1'b1;
                            n_state = S_SCAN;
                        end
                        MODE_QRY: begin
                            n_state = S_QRY;
                        end
                        MODE_NONE: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Reads go out one per cycle; each comes back from the memory's output register.
                if (r_issue) begin
                    n_beat = 1'b1;
                    if (r_addr == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + IDX_W'(1);
                    end
                end
                if (r_beat) begin
                    if ((r_mode == MODE_REL) && ram_rdata[ENTRY_W-1] &&
                        (ram_rdata[PID_W-1:0] == r_pid)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_beat_addr;
                    end
                    if (r_beat_addr == LAST_IDX) begin
                        n_state = (r_mode == MODE_REQ) ? S_DECIDE : S_DONE;
                    end
                end
            end
            S_DECIDE: begin
                if (!fit_found) begin
                    n_res.status = ST_NOMEM;
                    n_state      = S_DONE;
                end else begin
                    n_res.status        = ST_OK;
                    n_res.start_page    = 8'(fit_start);
                    n_res.pages_granted = 9'(r_need);
                    n_addr              = fit_start;
                    n_rem               = r_need;
                    // A zero-page grant leaves the table as it is.
                    n_state = (r_need == '0) ? S_DONE : S_FILL;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, r_pid};
                n_addr    = r_addr + IDX_W'(1);
                n_rem     = r_rem - CNT_W'(1);
                if (r_rem == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_QRY: begin
                if (r_q_ok) begin
                    if (ram_rdata[ENTRY_W-1]) begin
                        n_res.page_owner = ram_rdata[PID_W-1:0];
                    end else begin
                        n_res.page_free = 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_res.page_owner, r_res.page_free,
                                   r_res.pages_granted, r_res.start_page,
                                   r_res.status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_beat      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_beat      <= n_beat;
            r_out_valid <= n_out_valid;
        end
        r_beat_addr <= n_beat_addr;
        r_rem       <= n_rem;
        r_mode      <= n_mode;
        r_pid       <= n_pid;
        r_policy    <= n_policy;
        r_need      <= n_need;
        r_q_ok      <= n_q_ok;
        r_res       <= n_res;
        r_out_data  <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A chosen run always holds the whole grant inside the table.
    `CPA_ASSERT_RST(a_grant_in_table, i_clk, i_rst_n, (r_state == S_DECIDE && fit_found) |-> ((32'(fit_start) + 32'(r_need)) <= PAGE_COUNT))
    // The table is written only by the clearing pass, a release scan or a fill.
    `CPA_ASSERT_RST(a_write_phase, i_clk, i_rst_n, ram_we |-> (r_state == S_CLEAR || r_state == S_SCAN || r_state == S_FILL))
    // A finished result waits while the output register is still occupied.
    `CPA_ASSERT_RST(a_done_waits, i_clk, i_rst_n, (r_state == S_DONE && r_out_valid && !i_m_tready) |=> (r_state == S_DONE))

endmodule

// File: bench/page_alloc_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the page allocator. Every accepted command
// runs through a private copy of the owner table to produce the response the
// block owes; every accepted response is matched against the oldest one owed.
module page_alloc_checker #(
    parameter int PAGE_COUNT = 256,
    parameter int PAGE_SIZE  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    output int          o_errors,
    output int          o_pending
);

    logic             page_taken  [PAGE_COUNT];
    logic [3:0]       page_holder [PAGE_COUNT];
    cpa_pkg::t_result owed_responses[$];
    int               err_count = 0;

    assign o_errors = err_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t ns: %s is %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Walks the maximal free runs. A run only replaces the current pick when it
    // is strictly better, so ties keep the earliest run and first fit never
    // moves past the first run that is long enough.
    function automatic bit locate_free_run(input int need, input cpa_pkg::t_policy pol,
                                           output int run_start);
        int i, j, run_len, pick_start, pick_len;
        bit found;
        found      = 1'b0;
        pick_start = 0;
        pick_len   = 0;
        i          = 0;
        while (i < PAGE_COUNT) begin
            if (page_taken[i]) begin
                i++;
            end else begin
                j = i;
                while (j < PAGE_COUNT && !page_taken[j]) j++;
                run_len = j - i;
                if (run_len >= need) begin
                    if (!found || (pol == cpa_pkg::POL_BEST && run_len < pick_len) ||
                        (pol == cpa_pkg::POL_WORST && run_len > pick_len)) begin
                        found      = 1'b1;
                        pick_len   = run_len;
                        pick_start = i;
                    end
                end
                i = j;
            end
        end
        run_start = pick_start;
        return found;
    endfunction

    // Applies one command to the table copy and returns the response it earns.
    function automatic cpa_pkg::t_result predict_response(input logic [39:0] cmd);
        cpa_pkg::t_mode   op;
        cpa_pkg::t_policy pol;
        logic [3:0]       pid;
        logic [20:0]      size;
        logic [7:0]       pidx;
        int               need, first_page;
        bit               placed;
        cpa_pkg::t_result res;
        op   = cpa_pkg::t_mode'(cmd[1:0]);
        pid  = cmd[5:2];
        size = cmd[26:6];
        pol  = cpa_pkg::t_policy'(cmd[28:27]);
        pidx = cmd[36:29];
        res  = '0;
        case (op)
            cpa_pkg::MODE_REQ: begin
                if (pol == cpa_pkg::POL_BAD) begin
                    res.status = cpa_pkg::ST_BADPOL;
                end else begin
                    need   = (int'(size) + PAGE_SIZE - 1) / PAGE_SIZE;
                    placed = 1'b0;
                    if (need <= PAGE_COUNT) placed = locate_free_run(need, pol, first_page);
                    if (!placed) begin
                        res.status = cpa_pkg::ST_NOMEM;
                    end else begin
                        for (int k = first_page; k < first_page + need; k++) begin
                            page_taken[k]  = 1'b1;
                            page_holder[k] = pid;
                        end
                        res.status        = cpa_pkg::ST_OK;
                        res.start_page    = first_page[7:0];
                        res.pages_granted = need[8:0];
                    end
                end
            end
            cpa_pkg::MODE_REL: begin
                for (int k = 0; k < PAGE_COUNT; k++) begin
                    if (page_taken[k] && page_holder[k] == pid) begin
                        page_taken[k]  = 1'b0;
                        page_holder[k] = '0;
                    end
                end
            end
            cpa_pkg::MODE_QRY: begin
                if (int'(pidx) < PAGE_COUNT) begin
                    if (page_taken[pidx]) res.page_owner = page_holder[pidx];
                    else                  res.page_free  = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        cpa_pkg::t_result want, got;
        if (!i_rst_n) begin
            for (int k = 0; k < PAGE_COUNT; k++) begin
                page_taken[k]  = 1'b0;
                page_holder[k] = '0;
            end
            owed_responses.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) owed_responses.push_back(predict_response(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.status        = cpa_pkg::t_status'(i_m_tdata[1:0]);
                got.start_page    = i_m_tdata[9:2];
                got.pages_granted = i_m_tdata[18:10];
                got.page_free     = i_m_tdata[19];
                got.page_owner    = i_m_tdata[23:20];
                if (owed_responses.size() == 0) begin
                    report_mismatch("response with none owed, tdata", i_m_tdata, 0);
                end else begin
                    want = owed_responses.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.start_page != want.start_page)
                        report_mismatch("start_page", got.start_page, want.start_page);
                    if (got.pages_granted != want.pages_granted)
                        report_mismatch("pages_granted", got.pages_granted, want.pages_granted);
                    if (got.page_free != want.page_free)
                        report_mismatch("page_free", got.page_free, want.page_free);
                    if (got.page_owner != want.page_owner)
                        report_mismatch("page_owner", got.page_owner, want.page_owner);
                end
            end
        end
        o_pending <= owed_responses.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

// Top of the allocator bench. This module only makes stimulus and gives the
// verdict; the checker beside the block predicts and compares every response.
module testbench;

    localparam int PAGE_COUNT   = 256;
    localparam int PAGE_SIZE    = 4096;
    localparam int RANDOM_CMDS  = 1170;
    // A request may take a full scan plus a full write back before its
    // response leaves, so the drain wait covers that with some margin.
    localparam int DRAIN_CYCLES = 700;
    // The slowest correct run is roughly 1200 commands, each behind a long
    // sender gap and a long receiver stall, plus the table clearing pass
    // after reset. The limit is several times that.
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int SIZE_MAX     = (1 << 21) - 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // mode[1:0], process_id[5:2], size_bytes[26:6], fit_policy[28:27],
    // page_index[36:29], zeros above
    logic [39:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // status[1:0], start_page[9:2], pages_granted[18:10], page_free[19],
    // page_owner[23:20]
    logic [23:0] o_m_tdata;

    int error_total;
    int owed_total;
    int cycle_count = 0;
    int calm_left   = 0;

    contiguous_page_allocator_unit #(
        .PAGE_COUNT(PAGE_COUNT),
        .PAGE_SIZE (PAGE_SIZE)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    page_alloc_checker #(
        .PAGE_COUNT(PAGE_COUNT),
        .PAGE_SIZE (PAGE_SIZE)
    ) i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .i_m_tdata (o_m_tdata),
        .o_errors  (error_total),
        .o_pending (owed_total)
    );

    // The clock runs at 100 MHz.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A run that never drains ends here with a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Sender idle time between transactions. Most gaps are short and a few
    // are long. Now and then a calm stretch sends back to back, so commands
    // also land right as the block finishes its previous one.
    function automatic int next_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)  calm_left = $urandom_range(10, 40);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Presents one command and returns at the edge where the transaction is
    // accepted. The ready seen at the falling edge is what the block shows at
    // the next rising edge, so the test never races the block's own update.
    task automatic issue_command(input cpa_pkg::t_mode op, input logic [3:0] pid,
                                 input logic [20:0] size, input cpa_pkg::t_policy pol,
                                 input logic [7:0] pidx);
        int  gap;
        bit  ready_seen;
        gap = next_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, pidx, pol, size, pid, op};
        do begin
            @(negedge i_clk);
            ready_seen = o_s_tready;
            @(posedge i_clk);
        end while (!ready_seen);
    endtask

    // Request sizes are mostly small, with a partial last page, so the table
    // fragments into runs of mixed length where the three policies disagree.
    // A few are exact page multiples, zero bytes, or drawn from the whole
    // field range, which also reaches every high bit of the size.
    function automatic logic [20:0] pick_request_size();
        int r, pages;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            pages = $urandom_range(1, 12);
            return 21'(pages * PAGE_SIZE - $urandom_range(0, PAGE_SIZE - 1));
        end
        if (r < 85) begin
            pages = $urandom_range(13, 64);
            return 21'(pages * PAGE_SIZE - $urandom_range(0, PAGE_SIZE - 1));
        end
        if (r < 92) return 21'($urandom_range(1, 40) * PAGE_SIZE);
        if (r < 95) return 21'd0;
        return 21'($urandom_range(0, SIZE_MAX));
    endfunction

    // One random command. Requests dominate so the table stays busy, releases
    // keep carving holes into it, and queries look at random pages. Fields a
    // mode does not use carry random noise, which the block has to ignore.
    task automatic send_random_command();
        int               r;
        cpa_pkg::t_policy pol;
        r   = $urandom_range(0, 99);
        pol = ($urandom_range(0, 99) < 94) ? cpa_pkg::t_policy'($urandom_range(0, 2))
                                           : cpa_pkg::POL_BAD;
        if (r < 55)
            issue_command(cpa_pkg::MODE_REQ, 4'($urandom_range(0, 15)), pick_request_size(),
                          pol, 8'($urandom_range(0, 255)));
        else if (r < 72)
            issue_command(cpa_pkg::MODE_REL, 4'($urandom_range(0, 15)),
                          21'($urandom_range(0, SIZE_MAX)), cpa_pkg::t_policy'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
        else if (r < 97)
            issue_command(cpa_pkg::MODE_QRY, 4'($urandom_range(0, 15)),
                          21'($urandom_range(0, SIZE_MAX)), cpa_pkg::t_policy'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
        else
            issue_command(cpa_pkg::MODE_NONE, 4'($urandom_range(0, 15)),
                          21'($urandom_range(0, SIZE_MAX)), cpa_pkg::t_policy'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
    endtask

    // Holds the response ready at one level for a number of cycles.
    task automatic hold_ready(input logic level, input int cycles);
        i_m_tready <= level;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Receiver back pressure. Short and occasional long stalls fall on every
    // phase of the block's work; some stretches never stall at all.
    initial begin
        int r;
        hold_ready(1'b0, 1);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                hold_ready(1'b1, $urandom_range(50, 400));
            end else begin
                hold_ready(1'b1, $urandom_range(1, 8));
                r = $urandom_range(0, 99);
                if (r < 70)      hold_ready(1'b0, $urandom_range(1, 3));
                else if (r < 95) hold_ready(1'b0, $urandom_range(4, 20));
                else             hold_ready(1'b0, $urandom_range(40, 120));
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. The block holds off commands during its clearing
        // pass, which the handshake absorbs.
        // A fresh table reports page zero free.
        issue_command(cpa_pkg::MODE_QRY, 4'd0, 21'd0, cpa_pkg::POL_FIRST, 8'd0);
        // A zero-byte request still needs a free run and grants nothing.
        issue_command(cpa_pkg::MODE_REQ, 4'd15, 21'd0, cpa_pkg::POL_FIRST, 8'd0);
        // Best fit has to accept the one run that spans the whole memory,
        // and the full page count must survive in the granted field.
        issue_command(cpa_pkg::MODE_REQ, 4'd1, 21'd1048576, cpa_pkg::POL_BEST, 8'd0);
        issue_command(cpa_pkg::MODE_QRY, 4'd0, 21'd0, cpa_pkg::POL_FIRST, 8'd255);
        // With no page free even a zero-byte request runs out of memory.
        issue_command(cpa_pkg::MODE_REQ, 4'd2, 21'd0, cpa_pkg::POL_WORST, 8'd0);
        // The policy check comes before any size check.
        issue_command(cpa_pkg::MODE_REQ, 4'd2, 21'd1, cpa_pkg::POL_BAD, 8'd0);
        issue_command(cpa_pkg::MODE_REL, 4'd1, 21'd0, cpa_pkg::POL_FIRST, 8'd0);
        // The largest size field asks for more pages than the memory has.
        issue_command(cpa_pkg::MODE_REQ, 4'd3, 21'(SIZE_MAX), cpa_pkg::POL_FIRST, 8'd0);
        // One byte and one page plus a byte both round up.
        issue_command(cpa_pkg::MODE_REQ, 4'd3, 21'd1, cpa_pkg::POL_FIRST, 8'd0);
        issue_command(cpa_pkg::MODE_REQ, 4'd4, 21'd4097, cpa_pkg::POL_WORST, 8'd0);
        issue_command(cpa_pkg::MODE_REQ, 4'd5, 21'(3 * PAGE_SIZE), cpa_pkg::POL_FIRST, 8'd0);
        // Opening a two-page hole in front of the large tail gives the
        // policies different choices.
        issue_command(cpa_pkg::MODE_REL, 4'd4, 21'd0, cpa_pkg::POL_FIRST, 8'd0);
        issue_command(cpa_pkg::MODE_REQ, 4'd6, 21'(PAGE_SIZE), cpa_pkg::POL_BEST, 8'd0);
        issue_command(cpa_pkg::MODE_REQ, 4'd7, 21'(PAGE_SIZE), cpa_pkg::POL_WORST, 8'd0);
        issue_command(cpa_pkg::MODE_REQ, 4'd8, 21'(2 * PAGE_SIZE), cpa_pkg::POL_FIRST, 8'd0);
        issue_command(cpa_pkg::MODE_QRY, 4'd0, 21'd0, cpa_pkg::POL_FIRST, 8'd1);
        issue_command(cpa_pkg::MODE_QRY, 4'd0, 21'd0, cpa_pkg::POL_FIRST, 8'd2);
        // The unused mode with every field at its top value changes nothing.
        issue_command(cpa_pkg::MODE_NONE, 4'd15, 21'(SIZE_MAX), cpa_pkg::POL_BAD, 8'd255);
        // Releasing a process that owns nothing still answers ok.
        issue_command(cpa_pkg::MODE_REL, 4'd0, 21'(SIZE_MAX), cpa_pkg::POL_BAD, 8'd255);
        issue_command(cpa_pkg::MODE_REQ, 4'd15, 21'(250 * PAGE_SIZE), cpa_pkg::POL_FIRST, 8'd0);
        issue_command(cpa_pkg::MODE_REQ, 4'd15, 21'(200 * PAGE_SIZE), cpa_pkg::POL_WORST, 8'd0);
        issue_command(cpa_pkg::MODE_QRY, 4'd0, 21'd0, cpa_pkg::POL_FIRST, 8'd7);
        issue_command(cpa_pkg::MODE_REL, 4'd15, 21'd0, cpa_pkg::POL_FIRST, 8'd0);

        for (int n = 0; n < RANDOM_CMDS; n++) send_random_command();
        i_s_tvalid <= 1'b0;

        // Wait until every owed response has arrived, then give the block
        // time to show any stray response. The count is read at a falling
        // edge, after the checker has taken the last transaction.
        do @(negedge i_clk); while (owed_total != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
